[sv/atte_pkg.sv]
// ----------------------------------------------------------------------------
// atte_pkg
// Shared types, geometry and palette for the ANSI text terminal engine.
// ----------------------------------------------------------------------------
package atte_pkg;

  localparam int COLUMNS    = 160;
  localparam int ROWS       = 90;
  localparam int MAX_PARAMS = 8;
  localparam int SEQ_LIMIT  = 23;

  localparam int PIDX_W = $clog2(MAX_PARAMS);
  localparam int PCNT_W = $clog2(MAX_PARAMS + 1);

  localparam logic [23:0] WHITE    = 24'hFFFFFF;
  localparam logic [23:0] BLACK    = 24'h000000;
  localparam logic [23:0] FORE_RST = 24'hAAAAAA;

  // input operations
  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_BS   = 2'd1;
  localparam logic [1:0] OP_MARK = 2'd2;

  // result kinds
  localparam logic [1:0] K_DRAW   = 2'd0;
  localparam logic [1:0] K_SPAN   = 2'd1;
  localparam logic [1:0] K_CLEAR  = 2'd2;
  localparam logic [1:0] K_SCROLL = 2'd3;

  // commands from front to back
  typedef enum logic [3:0] {
    C_TEXT, C_NL, C_BS, C_MARK, C_SGR, C_CUP, C_CUU, C_CUD, C_CUF, C_CUB,
    C_ED, C_EL, C_NONE
  } cmd_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  col;
    logic [7:0]  col_end;
    logic [6:0]  row;
    logic [7:0]  glyph;
    logic [23:0] fore;
    logic [23:0] back;
    logic        last;
  } out_t;

  typedef struct packed {
    cmd_e                         cmd;
    logic [7:0]                   ch;
    logic [PCNT_W-1:0]            pcnt;
    logic [MAX_PARAMS-1:0][15:0]  pv;
  } cmd_t;

  function automatic logic [23:0] dark(input logic [2:0] i);
    case (i)
      3'd0: dark = 24'h000000;
      3'd1: dark = 24'hAA0000;
      3'd2: dark = 24'h00AA00;
      3'd3: dark = 24'hAA5500;
      3'd4: dark = 24'h0000AA;
      3'd5: dark = 24'hAA00AA;
      3'd6: dark = 24'h00AAAA;
      default: dark = 24'hAAAAAA;
    endcase
  endfunction

  function automatic logic [23:0] bright(input logic [2:0] i);
    case (i)
      3'd0: bright = 24'h555555;
      3'd1: bright = 24'hFF5555;
      3'd2: bright = 24'h55FF55;
      3'd3: bright = 24'hFFFF55;
      3'd4: bright = 24'h5555FF;
      3'd5: bright = 24'hFF55FF;
      3'd6: bright = 24'h55FFFF;
      default: bright = 24'hFFFFFF;
    endcase
  endfunction

endpackage

[sv/atte_front.sv]
// ----------------------------------------------------------------------------
// atte_front
// Escape parser: classifies bytes and collects CSI parameters into commands.
// ----------------------------------------------------------------------------
module atte_front import atte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  in_t  in_data,
  output logic in_ready,
  output logic cmd_valid,
  output cmd_t cmd_data,
  input  logic cmd_ready
);

  logic [1:0]                  mode;
  logic [4:0]                  seq_len;
  logic [PCNT_W-1:0]           pcnt;
  logic [MAX_PARAMS-1:0][15:0] pv;
  logic [15:0]                 acc;
  logic                        seen;
  logic                        stopped;

  logic        is_final, is_dig;
  logic [19:0] acc_x10;
  logic [15:0] acc_sat;
  cmd_t        c;
  logic        emit;

  assign in_ready = cmd_ready;
  assign is_dig   = in_data.char_in inside {[8'h30:8'h39]};
  assign is_final = in_data.char_in inside {"m", "J", "H", "f", "A", "B", "C", "D", "K"};
  assign acc_x10  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, in_data.char_in[3:0]};
  assign acc_sat  = (acc_x10 > 20'd65535) ? 16'hFFFF : acc_x10[15:0];

  always_comb begin
    c       = '0;
    c.cmd   = C_NONE;
    c.ch    = in_data.char_in;
    c.pcnt  = pcnt;
    c.pv    = pv;
    emit    = 1'b1;
    case (in_data.op)
      OP_BS:   c.cmd = C_BS;
      OP_MARK: c.cmd = C_MARK;
      OP_CHAR: begin
        if (mode == 2'd2) begin
          if (is_final) begin
            // final byte: flush a pending value
            if (!stopped && seen && pcnt < PCNT_W'(MAX_PARAMS)) begin
              c.pv[pcnt[PIDX_W-1:0]] = acc;
              c.pcnt = pcnt + 1'b1;
            end
            case (in_data.char_in)
              "m":      c.cmd = C_SGR;
              "H", "f": c.cmd = C_CUP;
              "A":      c.cmd = C_CUU;
              "B":      c.cmd = C_CUD;
              "C":      c.cmd = C_CUF;
              "D":      c.cmd = C_CUB;
              "J":      c.cmd = C_ED;
              default:  c.cmd = C_EL;
            endcase
          end else begin
            emit = 1'b0;
          end
        end else if (mode == 2'd1 && in_data.char_in == "[") begin
          emit = 1'b0;
        end else if (in_data.char_in == 8'h1B) begin
          emit = 1'b0;
        end else if (in_data.char_in == 8'h0A) begin
          c.cmd = C_NL;
        end else begin
          c.cmd = C_TEXT;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign cmd_valid = in_valid && emit;
  assign cmd_data  = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 2'd0; seq_len <= '0; pcnt <= '0; acc <= '0;
      seen <= 1'b0; stopped <= 1'b0;
    end else if (in_valid && in_ready && in_data.op == OP_CHAR) begin
      if (mode == 2'd2) begin
        if (is_final) begin
          mode <= 2'd0;
        end else if (seq_len < 5'(SEQ_LIMIT)) begin
          seq_len <= seq_len + 1'b1;
          if (!stopped) begin
            if (is_dig) begin
              acc <= acc_sat; seen <= 1'b1;
            end else begin
              if (in_data.char_in != 8'h00 || seen) begin
                if (pcnt < PCNT_W'(MAX_PARAMS)) begin
                  pv[pcnt[PIDX_W-1:0]] <= acc;
                  pcnt <= pcnt + 1'b1;
                end
                acc <= '0; seen <= 1'b0;
              end
              if (in_data.char_in != ";") stopped <= 1'b1;
            end
          end
        end
      end else if (mode == 2'd1 && in_data.char_in == "[") begin
        mode <= 2'd2; seq_len <= '0; pcnt <= '0; acc <= '0;
        seen <= 1'b0; stopped <= 1'b0;
      end else if (in_data.char_in == 8'h1B) begin
        mode <= 2'd1;
      end else begin
        mode <= 2'd0;
      end
    end
  end

endmodule

[sv/atte_fifo.sv]
// ----------------------------------------------------------------------------
// atte_fifo
// Two-entry command queue between parser and executor.
// ----------------------------------------------------------------------------
module atte_fifo import atte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  cmd_t wr_data,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_data,
  input  logic rd_ready
);

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

[sv/atte_back.sv]
// ----------------------------------------------------------------------------
// atte_back
// Executor: cursor, colors, SGR walk and result generation.
// ----------------------------------------------------------------------------
module atte_back import atte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd_data,
  output logic cmd_ready,
  output logic res_valid,
  output out_t res_data,
  input  logic res_ready
);

  typedef enum logic [1:0] {S_IDLE, S_SGR, S_OUT1, S_OUT2} state_e;

  state_e            state;
  logic [7:0]        cx, mx;
  logic [6:0]        cy, my;
  logic [23:0]       fg, bg;
  cmd_t              cur;
  logic [PIDX_W:0]   pidx;
  out_t              r1, r2;

  logic [15:0] n0, n1, nm, pn;
  logic [16:0] sx, sy;
  logic [2:0]  bi;
  logic        bhit;
  logic [23:0] fg_n, bg_n;

  assign n0 = (cmd_data.pcnt > 0) ? cmd_data.pv[0] : 16'd0;
  assign n1 = (cmd_data.pcnt > 1) ? cmd_data.pv[1] : 16'd0;
  assign nm = (n0 == 0) ? 16'd1 : n0;
  assign sx = {9'd0, cx} + {1'b0, nm};
  assign sy = {10'd0, cy} + {1'b0, nm};

  assign cmd_ready = (state == S_IDLE) && !res_valid;
  assign res_valid = (state == S_OUT1) || (state == S_OUT2);
  assign res_data  = (state == S_OUT2) ? r2 : r1;

  // one stored parameter per cycle
  assign pn = cur.pv[pidx[PIDX_W-1:0]];
  always_comb begin
    bhit = 1'b0; bi = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (fg == dark(3'(i))) begin
        bhit = 1'b1; bi = 3'(i);
      end
    end
    fg_n = fg; bg_n = bg;
    if (pn == 16'd0) begin
      fg_n = WHITE; bg_n = BLACK;
    end else if (pn == 16'd1) begin
      if (bhit) fg_n = bright(bi);
    end else if (pn inside {[16'd30:16'd37]}) fg_n = dark(pn[2:0] - 3'd6);
    else if (pn == 16'd39) fg_n = WHITE;
    else if (pn inside {[16'd40:16'd47]}) bg_n = dark(pn[2:0]);
    else if (pn == 16'd49) bg_n = BLACK;
    else if (pn inside {[16'd90:16'd97]}) fg_n = bright(pn[2:0] - 3'd2);
    else if (pn inside {[16'd100:16'd107]}) bg_n = bright(pn[2:0] - 3'd4);
  end

  function automatic out_t mk(input logic [1:0] k, input logic [7:0] c0,
                              input logic [7:0] c1, input logic [6:0] rw,
                              input logic [7:0] g, input logic [23:0] f,
                              input logic [23:0] b, input logic l);
    out_t o;
    o.kind = k; o.col = c0; o.col_end = c1; o.row = rw; o.glyph = g;
    o.fore = f; o.back = b; o.last = l;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cx <= '0; cy <= '0; mx <= '0; my <= '0;
      fg <= FORE_RST; bg <= BLACK; pidx <= '0;
    end else begin
      case (state)
        S_IDLE: if (cmd_valid && cmd_ready) begin
          cur <= cmd_data;
          case (cmd_data.cmd)
            C_TEXT: begin
              if (cx == 8'(COLUMNS - 1)) begin
                cx <= '0;
                if (cy == 7'(ROWS - 1)) begin
                  r1 <= mk(K_DRAW, cx, cx, cy, cmd_data.ch, fg, bg, 1'b0);
                  r2 <= mk(K_SCROLL, 8'd0, 8'(COLUMNS - 1), 7'(ROWS - 1),
                           8'h20, fg, bg, 1'b1);
                end else begin
                  cy <= cy + 1'b1;
                  r1 <= mk(K_DRAW, cx, cx, cy, cmd_data.ch, fg, bg, 1'b1);
                end
              end else begin
                cx <= cx + 1'b1;
                r1 <= mk(K_DRAW, cx, cx, cy, cmd_data.ch, fg, bg, 1'b1);
              end
              state <= S_OUT1;
            end
            C_NL: begin
              cx <= '0;
              if (cy == 7'(ROWS - 1)) begin
                r1 <= mk(K_SCROLL, 8'd0, 8'(COLUMNS - 1), 7'(ROWS - 1),
                         8'h20, fg, bg, 1'b1);
                state <= S_OUT1;
              end else cy <= cy + 1'b1;
            end
            C_BS: begin
              if (!(cx == mx && cy == my) && !(cx == 0 && cy == 0)) begin
                if (cx == 0) begin
                  cy <= cy - 1'b1; cx <= 8'(COLUMNS - 1);
                  r1 <= mk(K_DRAW, 8'(COLUMNS - 1), 8'(COLUMNS - 1), cy - 1'b1,
                           8'h20, fg, bg, 1'b1);
                end else begin
                  cx <= cx - 1'b1;
                  r1 <= mk(K_DRAW, cx - 1'b1, cx - 1'b1, cy, 8'h20, fg, bg, 1'b1);
                end
                state <= S_OUT1;
              end
            end
            C_MARK: begin
              mx <= cx; my <= cy;
            end
            C_SGR: begin
              if (cmd_data.pcnt == 0) begin
                fg <= WHITE; bg <= BLACK;
              end else begin
                pidx <= '0; state <= S_SGR;
              end
            end
            C_CUP: begin
              cy <= (n0 == 0) ? 7'd0 : (n0 > 16'(ROWS)) ? 7'(ROWS - 1) : 7'(n0 - 1);
              cx <= (n1 == 0) ? 8'd0 :
                    (n1 > 16'(COLUMNS)) ? 8'(COLUMNS - 1) : 8'(n1 - 1);
            end
            C_CUU: cy <= ({9'd0, cy} >= nm) ? 7'({9'd0, cy} - nm) : 7'd0;
            C_CUD: cy <= (sy >= 17'(ROWS)) ? 7'(ROWS - 1) : sy[6:0];
            C_CUF: cx <= (sx >= 17'(COLUMNS)) ? 8'(COLUMNS - 1) : sx[7:0];
            C_CUB: cx <= ({8'd0, cx} >= nm) ? 8'({8'd0, cx} - nm) : 8'd0;
            C_ED: if (n0 == 16'd2) begin
              r1 <= mk(K_CLEAR, 8'd0, 8'(COLUMNS - 1), 7'd0, 8'h20, fg, bg, 1'b1);
              cx <= '0; cy <= '0; state <= S_OUT1;
            end
            C_EL: begin
              if (n0 <= 16'd2) state <= S_OUT1;
              case (n0[1:0])
                2'd0: r1 <= mk(K_SPAN, cx, 8'(COLUMNS - 1), cy, 8'h20, fg, bg, 1'b1);
                2'd1: r1 <= mk(K_SPAN, 8'd0, cx, cy, 8'h20, fg, bg, 1'b1);
                default: r1 <= mk(K_SPAN, 8'd0, 8'(COLUMNS - 1), cy, 8'h20,
                                  fg, bg, 1'b1);
              endcase
            end
            default: ;
          endcase
        end
        S_SGR: begin
          fg <= fg_n; bg <= bg_n;
          pidx <= pidx + 1'b1;
          if (pidx + 1'b1 == (PIDX_W+1)'(cur.pcnt)) state <= S_IDLE;
        end
        S_OUT1: if (res_ready) state <= r1.last ? S_IDLE : S_OUT2;
        S_OUT2: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/ansi_text_terminal_engine.sv]
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine
// Terminal byte stream to draw commands: parser front, queue, executor back.
// ----------------------------------------------------------------------------
// Path: a byte's command is written into the queue, taken from it by the
// executor and registered there as a result on dout until it is popped.
// The executor takes no new command while a result is pending or while an
// SGR terminator walks its stored parameters; a second result is held on
// dout after the first one is popped.
// Reset: synchronous rst clears parser, cursor, mark, colors and the queue.
module ansi_text_terminal_engine import atte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  din,
  output logic full,
  output logic empty,
  output out_t dout,
  input  logic pop
);

  // front to queue
  logic f_valid, f_ready;
  cmd_t f_cmd;
  // queue to back
  logic q_valid, q_ready;
  cmd_t q_cmd;
  logic in_ready, res_valid;

  atte_front u_front (
    .clk, .rst,
    .in_valid(push), .in_data(din), .in_ready(in_ready),
    .cmd_valid(f_valid), .cmd_data(f_cmd), .cmd_ready(f_ready)
  );

  atte_fifo u_fifo (
    .clk, .rst,
    .wr_valid(f_valid), .wr_data(f_cmd), .wr_ready(f_ready),
    .rd_valid(q_valid), .rd_data(q_cmd), .rd_ready(q_ready)
  );

  atte_back u_back (
    .clk, .rst,
    .cmd_valid(q_valid), .cmd_data(q_cmd), .cmd_ready(q_ready),
    .res_valid(res_valid), .res_data(dout), .res_ready(pop)
  );

  // the parser only takes a byte when the queue has room for its command
  assign full  = !in_ready;
  assign empty = !res_valid;

  // a result without last is always followed by the second one
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !dout.last) |=> !empty)
    else $error("last handling");
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && dout.kind == K_SCROLL) |-> dout.row == 7'(ROWS - 1))
    else $error("scroll row");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(dout))
    else $error("result dropped");
endmodule
